>>> src/scsd_pkg.sv
package scsd_pkg;

    localparam logic [7:0] CODE_EXT   = 8'hE0;
    localparam logic [7:0] CODE_REL   = 8'hF0;
    localparam logic [7:0] TABLE_SPAN = 8'h7E;

    localparam logic [2:0] MOD_SHIFT = 3'h1;
    localparam logic [2:0] MOD_PAD   = 3'h2;
    localparam logic [2:0] MOD_CTL   = 3'h4;

    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_LSHIFT,
        ACT_RSHIFT,
        ACT_NUM,
        ACT_CAPS,
        ACT_LEFT,
        ACT_DOWN,
        ACT_RIGHT,
        ACT_UP,
        ACT_SCR_UP,
        ACT_SCR_DOWN
    } t_act;

    typedef enum logic [2:0] {
        KIND_CHAR,
        KIND_LEFT,
        KIND_DOWN,
        KIND_RIGHT,
        KIND_UP,
        KIND_SCR_UP,
        KIND_SCR_DOWN
    } t_kind;

    // up to four characters, ch[0] goes out first
    typedef struct packed {
        logic [2:0]      len;
        logic [3:0][6:0] ch;
    } t_str;

    typedef struct packed {
        logic [2:0] mods;
        t_act       act;
        t_str       plain;
        t_str       shifted;
        t_str       pad;
    } t_key;

    typedef struct packed {
        logic ext;
        logic rel;
        logic lsh;
        logic rsh;
        logic num;
        logic caps;
    } t_flags;

    typedef struct packed {
        t_flags          flags;
        t_kind           kind;
        logic [2:0]      cnt;
        logic [3:0][6:0] chars;
    } t_dec;

    localparam t_str STR_NONE = '{len: 3'd0, ch: 28'd0};
    localparam t_str STR_HOME = '{len: 3'd3, ch: {7'h00, 7'h48, 7'h5B, 7'h1B}};
    localparam t_str STR_END  = '{len: 3'd3, ch: {7'h00, 7'h46, 7'h5B, 7'h1B}};
    localparam t_str STR_DEL  = '{len: 3'd4, ch: {7'h7E, 7'h33, 7'h5B, 7'h1B}};

    localparam t_key KEY_NONE = '{
        mods: 3'd0, act: ACT_NONE, plain: STR_NONE, shifted: STR_NONE, pad: STR_NONE
    };

    function automatic t_str s1(input logic [7:0] c);
        t_str s;
        s.len = 3'd1;
        s.ch  = {21'd0, c[6:0]};
        return s;
    endfunction

    function automatic t_key k_sh(input logic [7:0] p, input logic [7:0] s);
        t_key k;
        k         = KEY_NONE;
        k.mods    = MOD_SHIFT;
        k.plain   = s1(p);
        k.shifted = s1(s);
        return k;
    endfunction

    function automatic t_key k_pl(input t_str p);
        t_key k;
        k       = KEY_NONE;
        k.plain = p;
        return k;
    endfunction

    function automatic t_key k_ct(input t_act a);
        t_key k;
        k      = KEY_NONE;
        k.mods = MOD_CTL;
        k.act  = a;
        return k;
    endfunction

    function automatic t_key k_kp(input t_str p, input logic [7:0] c);
        t_key k;
        k       = KEY_NONE;
        k.mods  = MOD_PAD;
        k.plain = p;
        k.pad   = s1(c);
        return k;
    endfunction

    function automatic t_key main_key(input logic [6:0] code);
        t_key k;
        unique case (code)
            7'h16: k = k_sh("1", "!");
            7'h1e: k = k_sh("2", "@");
            7'h26: k = k_sh("3", "#");
            7'h25: k = k_sh("4", "$");
            7'h2e: k = k_sh("5", "%");
            7'h36: k = k_sh("6", "^");
            7'h3d: k = k_sh("7", "&");
            7'h3e: k = k_sh("8", "*");
            7'h46: k = k_sh("9", "(");
            7'h45: k = k_sh("0", ")");
            7'h4e: k = k_sh("-", "_");
            7'h55: k = k_sh("=", "+");
            7'h5d: k = k_sh("\\", "|");
            7'h66: k = k_pl(s1(8'h08));
            7'h0d: k = k_pl(s1(8'h09));
            7'h15: k = k_sh("q", "Q");
            7'h1d: k = k_sh("w", "W");
            7'h24: k = k_sh("e", "E");
            7'h2d: k = k_sh("r", "R");
            7'h2c: k = k_sh("t", "T");
            7'h35: k = k_sh("y", "Y");
            7'h3c: k = k_sh("u", "U");
            7'h43: k = k_sh("i", "I");
            7'h44: k = k_sh("o", "O");
            7'h4d: k = k_sh("p", "P");
            7'h54: k = k_sh("[", "{");
            7'h5b: k = k_sh("]", "}");
            7'h5a: k = k_pl(s1(8'h0A));
            7'h58: k = k_ct(ACT_CAPS);
            7'h1c: k = k_sh("a", "A");
            7'h1b: k = k_sh("s", "S");
            7'h23: k = k_sh("d", "D");
            7'h2b: k = k_sh("f", "F");
            7'h34: k = k_sh("g", "G");
            7'h33: k = k_sh("h", "H");
            7'h3b: k = k_sh("j", "J");
            7'h42: k = k_sh("k", "K");
            7'h4b: k = k_sh("l", "L");
            7'h4c: k = k_sh(";", ":");
            7'h52: k = k_sh("'", "\"");
            7'h12: k = k_ct(ACT_LSHIFT);
            7'h1a: k = k_sh("z", "Z");
            7'h22: k = k_sh("x", "X");
            7'h21: k = k_sh("c", "C");
            7'h2a: k = k_sh("v", "V");
            7'h32: k = k_sh("b", "B");
            7'h31: k = k_sh("n", "N");
            7'h3a: k = k_sh("m", "M");
            7'h41: k = k_sh(",", "<");
            7'h49: k = k_sh(".", ">");
            7'h4a: k = k_sh("/", "?");
            7'h59: k = k_ct(ACT_RSHIFT);
            7'h14: k = k_ct(ACT_NONE);
            7'h11: k = k_ct(ACT_NONE);
            7'h29: k = k_pl(s1(" "));
            7'h77: k = k_ct(ACT_NUM);
            7'h7c: k = k_pl(s1("*"));
            7'h7b: k = k_pl(s1("-"));
            7'h79: k = k_pl(s1("+"));
            7'h73: k = k_pl(s1("5"));
            7'h6c: k = k_kp(STR_HOME, "7");
            7'h75: k = k_kp(STR_NONE, "8");
            7'h7d: k = k_kp(STR_NONE, "9");
            7'h6b: k = k_kp(STR_NONE, "4");
            7'h74: k = k_kp(STR_NONE, "6");
            7'h69: k = k_kp(STR_END, "1");
            7'h72: k = k_kp(STR_NONE, "2");
            7'h7a: k = k_kp(STR_NONE, "3");
            7'h70: begin
                k      = k_kp(STR_NONE, "0");
                k.mods = MOD_CTL | MOD_PAD;
            end
            7'h71: k = k_kp(STR_DEL, ".");
            default: k = KEY_NONE;
        endcase
        return k;
    endfunction

    function automatic t_key ext_key(input logic [6:0] code);
        t_key k;
        unique case (code)
            7'h11: k = k_ct(ACT_NONE);
            7'h14: k = k_ct(ACT_NONE);
            7'h70: k = k_ct(ACT_NONE);
            7'h71: k = k_pl(STR_DEL);
            7'h6c: k = k_pl(STR_HOME);
            7'h69: k = k_pl(STR_END);
            7'h7d: begin
                k      = KEY_NONE;
                k.mods = MOD_SHIFT;
                k.act  = ACT_SCR_UP;
            end
            7'h7a: begin
                k      = KEY_NONE;
                k.mods = MOD_SHIFT;
                k.act  = ACT_SCR_DOWN;
            end
            7'h6b: k = k_ct(ACT_LEFT);
            7'h72: k = k_ct(ACT_DOWN);
            7'h74: k = k_ct(ACT_RIGHT);
            7'h75: k = k_ct(ACT_UP);
            7'h4a: k = k_pl(s1("/"));
            7'h5a: k = k_pl(s1(8'h0A));
            default: k = KEY_NONE;
        endcase
        return k;
    endfunction

endpackage

>>> src/scsd_in_if.sv
interface scsd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] scan_code;

    modport source (output valid, output scan_code, input ready);
    modport sink   (input valid, input scan_code, output ready);
endinterface

>>> src/scsd_out_if.sv
interface scsd_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [6:0] char_out;
    logic       last;

    modport source (output valid, output kind, output char_out, output last, input ready);
    modport sink   (input valid, input kind, input char_out, input last, output ready);
endinterface

>>> src/scsd_decode.sv
module scsd_decode
    import scsd_pkg::*;
(
    input  logic [7:0] i_code,
    input  t_flags     i_flags,
    output t_dec       o_dec
);

    t_flags nf;
    t_key   key;
    logic   use_key;
    logic   sh;
    logic   rel;
    t_kind  kind;
    t_str   str;

    always_comb begin
        nf      = i_flags;
        key     = KEY_NONE;
        use_key = 1'b0;
        kind    = KIND_CHAR;
        str     = STR_NONE;
        sh      = i_flags.lsh | i_flags.rsh | i_flags.caps;
        rel     = i_flags.rel;

        if (i_flags.ext) begin
            if (i_code == CODE_REL) begin
                nf.rel = 1'b1;
            end else begin
                nf.ext = 1'b0;
                if (i_code < TABLE_SPAN) begin
                    use_key = 1'b1;
                    key     = ext_key(i_code[6:0]);
                end
            end
        end else if (i_code == CODE_EXT) begin
            nf.ext = 1'b1;
        end else if (i_code == CODE_REL) begin
            nf.rel = 1'b1;
        end else if (i_code < TABLE_SPAN) begin
            use_key = 1'b1;
            key     = main_key(i_code[6:0]);
        end

        if (use_key) begin
            if (((key.mods & MOD_SHIFT) != 3'd0) && sh) begin
                if (!rel) begin
                    if (key.act == ACT_SCR_UP) begin
                        kind = KIND_SCR_UP;
                    end else if (key.act == ACT_SCR_DOWN) begin
                        kind = KIND_SCR_DOWN;
                    end else begin
                        str = key.shifted;
                    end
                end
            end else if (((key.mods & MOD_PAD) != 3'd0) && i_flags.num) begin
                if (!rel) begin
                    str = key.pad;
                end
            end else if ((key.mods & MOD_CTL) != 3'd0) begin
                case (key.act)
                    ACT_LSHIFT: nf.lsh = !rel;
                    ACT_RSHIFT: nf.rsh = !rel;
                    ACT_NUM:    if (!rel) nf.num = !i_flags.num;
                    ACT_CAPS:   if (!rel) nf.caps = !i_flags.caps;
                    ACT_LEFT:   if (!rel) kind = KIND_LEFT;
                    ACT_DOWN:   if (!rel) kind = KIND_DOWN;
                    ACT_RIGHT:  if (!rel) kind = KIND_RIGHT;
                    ACT_UP:     if (!rel) kind = KIND_UP;
                    default:    ;
                endcase
            end else if (!rel) begin
                str = key.plain;
            end
            nf.rel = 1'b0;
        end

        o_dec.flags = nf;
        o_dec.kind  = kind;
        // an event is a single result with a zero character
        o_dec.cnt   = (kind != KIND_CHAR) ? 3'd1 : str.len;
        o_dec.chars = str.ch;
    end

endmodule

>>> src/scan_code_set2_to_text_unit.sv
// path: a scan code goes into the input register, is decoded, and loads the output buffer once it is free
// throughput: one scan code per cycle when it gives at most one result and the output accepts;
//   a code with more results (up to four) waits for the one-result-per-cycle output buffer to drain
// the input register takes the next code while the buffer still drains
// reset: synchronous active low, clears all key flags, the input register and the buffer
module scan_code_set2_to_text_unit
    import scsd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    scsd_in_if.sink    i_code,
    scsd_out_if.source o_res
);

    logic            r_in_valid;
    logic [7:0]      r_code;
    t_flags          r_flags;
    logic [2:0]      r_buf_n;
    logic [1:0]      r_buf_idx;
    t_kind           r_kind;
    logic [3:0][6:0] r_chars;

    t_dec dec;
    logic buf_free;
    logic advance;
    logic out_xfer;

    scsd_decode u_decode (
        .i_code  (r_code),
        .i_flags (r_flags),
        .o_dec   (dec)
    );

    assign out_xfer = o_res.valid && o_res.ready;
    assign buf_free = (r_buf_n == 3'd0) || ((r_buf_n == 3'd1) && o_res.ready);
    assign advance  = r_in_valid && buf_free;

    assign i_code.ready   = !r_in_valid || advance;
    assign o_res.valid    = (r_buf_n != 3'd0);
    assign o_res.kind     = r_kind;
    assign o_res.char_out = r_chars[r_buf_idx];
    assign o_res.last     = (r_buf_n == 3'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_flags    <= '0;
            r_buf_n    <= 3'd0;
            r_buf_idx  <= 2'd0;
        end else begin
            if (i_code.valid && i_code.ready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end

            if (advance) begin
                r_flags   <= dec.flags;
                r_buf_n   <= dec.cnt;
                r_buf_idx <= 2'd0;
            end else if (out_xfer) begin
                r_buf_n   <= r_buf_n - 3'd1;
                r_buf_idx <= r_buf_idx + 2'd1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_code.valid && i_code.ready) begin
            r_code <= i_code.scan_code;
        end
        if (advance) begin
            r_kind  <= dec.kind;
            r_chars <= dec.chars;
        end
    end

    a_buf_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_buf_n <= 3'd4)
        else $error("result buffer count out of range");

    a_event_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && (o_res.kind != KIND_CHAR)) |-> (o_res.last && (o_res.char_out == 7'd0)))
        else $error("event result not a single zero-character result");

    a_seq_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_xfer && !o_res.last) |=> (o_res.valid && (o_res.kind == $past(o_res.kind))))
        else $error("result sequence broken before its last transfer");

    a_drain_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_xfer && o_res.last && !advance) |=> !o_res.valid)
        else $error("result offered with no decoded code behind it");

    a_empty_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && (dec.cnt == 3'd0)) |=> !o_res.valid)
        else $error("code without results left the buffer valid");

endmodule
